FILE: src/polyphonic_sample_mixer_core_assert.svh
// Assertion macros shared by the sample mixer modules.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef POLYPHONIC_SAMPLE_MIXER_CORE_ASSERT_SVH
`define POLYPHONIC_SAMPLE_MIXER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PSM_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PSM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/psm_pkg.sv
// Shared constants, command codes and control structs of the sample mixer.
// Used by the controller, the datapath and the top level.
package psm_pkg;

  localparam int VOICES       = 8;
  localparam int SAMPLE_DEPTH = 65536;
  localparam int VIDX_W       = $clog2(VOICES);
  localparam int ADDR_W       = $clog2(SAMPLE_DEPTH);
  localparam int MEM_AW       = VIDX_W + ADDR_W;
  localparam int SAMPLE_W     = 16;
  localparam int LEN_W        = 17;
  localparam int GAIN_W       = 16;
  localparam int VCNT_W       = 4;
  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int OUT_W        = 21;
  localparam int SUM_W        = SAMPLE_W + VIDX_W;
  localparam int PROD_W       = SUM_W + GAIN_W + 1;
  localparam int FRAC_BITS    = 14;

  localparam logic [GAIN_W-1:0] MUTE_LIMIT   = GAIN_W'(1638);
  localparam logic [LEN_W-1:0]  MAX_LENGTH   = LEN_W'(65536);
  localparam logic [VCNT_W-1:0] VCNT_RESET   = VCNT_W'(8);
  localparam int                OUT_MAX      = 1048575;
  localparam int                OUT_MIN      = -1048576;

  // Item command codes.
  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_LENGTH  = 2'd1;
  localparam logic [1:0] CMD_TRIGGER = 2'd2;
  localparam logic [1:0] CMD_TICK    = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GAIN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VCOUNT  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              exec_item;   // accepted word that is not a tick
    logic              tick_start;  // accepted tick word, clear the sum
    logic              scan;        // visit one voice
    logic [VIDX_W-1:0] voice_idx;   // voice visited during scan
    logic              mul_en;      // scale the finished sum
    logic              out_load;    // load the output register
  } psm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_tick;   // the word at the input is a tick
    logic out_free;  // the output register can take a word this cycle
  } psm_stat_t;

endpackage

FILE: src/psm_ctrl.sv
// Sequencer of the sample mixer: accepts words and steps a tick through
// the voice scan, the drain, the scaling and the output load. Uses psm_pkg.
`include "polyphonic_sample_mixer_core_assert.svh"

module psm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  psm_pkg::psm_stat_t stat,
  output psm_pkg::psm_cmd_t  cmd_o
);
  import psm_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DRAIN  = 3'd2;
  localparam logic [2:0] ST_MULT   = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  localparam logic [VIDX_W-1:0] LAST_VOICE = VIDX_W'(VOICES - 1);

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [VIDX_W-1:0] k;
  logic [VIDX_W-1:0] k_next;

  // Next state and command decode.
  always_comb begin
    state_next = state;
    k_next     = k;
    cmd_o      = '0;
    cmd_o.voice_idx = k;
    in_stall   = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (stat.is_tick) begin
            cmd_o.tick_start = 1'b1;
            k_next           = '0;
            state_next       = ST_SCAN;
          end else begin
            cmd_o.exec_item = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (k == LAST_VOICE) begin
          state_next = ST_DRAIN;
        end else begin
          k_next = k + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_next = ST_MULT;
      end
      ST_MULT: begin
        cmd_o.mul_en = 1'b1;
        state_next   = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd_o.out_load = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and voice counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      k     <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
    end
  end

  // A tick word starts the scan at the first voice.
  `PSM_ASSERT_NEXT(a_tick_start, (state == ST_IDLE && in_valid && stat.is_tick), (state == ST_SCAN && k == '0), "tick did not start the scan at voice zero")
  // The scan leaves only after the last voice.
  `PSM_ASSERT_NEXT(a_scan_exit, (state == ST_SCAN && k != LAST_VOICE), (state == ST_SCAN), "scan ended before the last voice")
  // Scaling is always followed by the output load step.
  `PSM_ASSERT_NEXT(a_mult_finish, (state == ST_MULT), (state == ST_FINISH), "scaling not followed by finish")

endmodule

FILE: src/psm_datapath.sv
// Datapath of the sample mixer: configuration registers, per-voice state,
// sample store, accumulator, gain multiplier and output register. Uses psm_pkg.
`include "polyphonic_sample_mixer_core_assert.svh"

module psm_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  psm_pkg::psm_cmd_t                   cmd_i,
  output psm_pkg::psm_stat_t                  stat,
  input  logic [1:0]                          cmd,
  input  logic [psm_pkg::VIDX_W-1:0]          voice,
  input  logic [psm_pkg::ADDR_W-1:0]          word_addr,
  input  logic signed [psm_pkg::SAMPLE_W-1:0] word_data,
  input  logic [psm_pkg::LEN_W-1:0]           voice_length,
  input  logic                                cfg_we,
  input  logic [psm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [psm_pkg::CFG_W-1:0]           cfg_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [psm_pkg::OUT_W-1:0]    mixed_sample
);
  import psm_pkg::*;

  localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(OUT_MAX);
  localparam logic signed [PROD_W-1:0] SAT_LO = PROD_W'(OUT_MIN);

  // Configuration registers.
  logic [GAIN_W-1:0] gain;
  logic              enabled;
  logic [VCNT_W-1:0] voices_in_use;

  // Per-voice state.
  logic [ADDR_W-1:0] position [VOICES];
  logic [LEN_W-1:0]  length   [VOICES];
  logic [VOICES-1:0] playing;

  // Sample store.
  logic [SAMPLE_W-1:0] mem [VOICES*SAMPLE_DEPTH];
  logic [SAMPLE_W-1:0] rd_data;

  logic                     add_pend;
  logic signed [SUM_W-1:0]  acc;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] scaled;

  logic              active;
  logic              in_use;
  logic [ADDR_W-1:0] cur_pos;
  logic [LEN_W-1:0]  cur_len;
  logic [LEN_W-1:0]  next_pos;
  logic              visit;
  logic              past_end;
  logic              stop_after;
  logic [LEN_W-1:0]  sat_len;

  assign active     = enabled && (gain > MUTE_LIMIT);
  assign in_use     = ({1'b0, cmd_i.voice_idx} < voices_in_use);
  assign cur_pos    = position[cmd_i.voice_idx];
  assign cur_len    = length[cmd_i.voice_idx];
  assign next_pos   = {1'b0, cur_pos} + 1'b1;
  assign visit      = cmd_i.scan && active && in_use && playing[cmd_i.voice_idx];
  assign past_end   = ({1'b0, cur_pos} >= cur_len);
  assign stop_after = (next_pos >= cur_len) || (next_pos >= LEN_W'(SAMPLE_DEPTH));
  assign sat_len    = (voice_length > MAX_LENGTH) ? MAX_LENGTH : voice_length;

  assign stat.is_tick  = (cmd == CMD_TICK);
  assign stat.out_free = !out_valid || !out_stall;

  // Configuration writes; an unknown index is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain          <= '0;
      enabled       <= 1'b0;
      voices_in_use <= VCNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN:    gain          <= cfg_data[GAIN_W-1:0];
        REG_ENABLED: enabled       <= cfg_data[0];
        REG_VCOUNT:  voices_in_use <= cfg_data[VCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Voice lengths and positions; lengths hold until written, positions are cleared by a trigger and step on visits.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VOICES; i++) begin
        position[i] <= '0;
        length[i]   <= '0;
      end
    end else if (cmd_i.exec_item) begin
      if (cmd == CMD_LENGTH) begin
        length[voice] <= sat_len;
      end else if (cmd == CMD_TRIGGER) begin
        position[voice] <= '0;
      end
    end else if (visit && !past_end && !stop_after) begin
      position[cmd_i.voice_idx] <= next_pos[ADDR_W-1:0];
    end
  end

  // Playing flags: set by trigger, cleared when a voice runs out.
  always_ff @(posedge clk) begin
    if (rst) begin
      playing <= '0;
    end else if (cmd_i.exec_item && cmd == CMD_TRIGGER) begin
      playing[voice] <= 1'b1;
    end else if (visit && (past_end || stop_after)) begin
      playing[cmd_i.voice_idx] <= 1'b0;
    end
  end

  // Sample store: written by write words, read once per visited voice that has not passed its end.
  always_ff @(posedge clk) begin
    if (cmd_i.exec_item && cmd == CMD_WRITE) begin
      mem[{voice, word_addr}] <= word_data;
    end
    if (visit && !past_end) begin
      rd_data <= mem[{cmd_i.voice_idx, cur_pos}];
    end
  end

  // The read data arrives in the cycle after the visit.
  always_ff @(posedge clk) begin
    if (rst) begin
      add_pend <= 1'b0;
    end else begin
      add_pend <= visit && !past_end;
    end
  end

  // Voice sum.
  always_ff @(posedge clk) begin
    if (cmd_i.tick_start) begin
      acc <= '0;
    end else if (add_pend) begin
      acc <= acc + SUM_W'(signed'(rd_data));
    end
  end

  // Gain multiply; the gain is unsigned, so it gets a zero sign bit.
  always_ff @(posedge clk) begin
    if (cmd_i.mul_en) begin
      prod <= PROD_W'(acc) * signed'(PROD_W'({1'b0, gain}));
    end
  end

  // Arithmetic shift gives the floor of the division by 2^14.
  assign scaled = prod >>> FRAC_BITS;

  // Output register with saturation.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.out_load) begin
      if (scaled > SAT_HI) begin
        mixed_sample <= SAT_HI[OUT_W-1:0];
      end else if (scaled < SAT_LO) begin
        mixed_sample <= SAT_LO[OUT_W-1:0];
      end else begin
        mixed_sample <= scaled[OUT_W-1:0];
      end
    end
  end

  // A pending add always follows a scan step.
  `PSM_ASSERT_IMPL(a_add_after_scan, add_pend, $past(cmd_i.scan), "sample add without a scan step")
  // A muted or disabled block never adds a sample.
  `PSM_ASSERT_NEXT(a_mute_no_add, (cmd_i.scan && !active), !add_pend, "sample added while muted")
  // The sum is complete before it is scaled.
  `PSM_ASSERT_IMPL(a_mult_drained, cmd_i.mul_en, !add_pend, "scaling started with an add pending")

endmodule

FILE: src/polyphonic_sample_mixer_core.sv
// Top level of the polyphonic sample mixer.
// Joins psm_ctrl and psm_datapath; uses psm_pkg.
//
// Usage: the input channel (in_valid, in_stall) carries one word per item:
// cmd selects a sample write, a length set, a voice trigger or a tick, with
// voice, word_addr, word_data and voice_length as operands. Only a tick
// produces an output word, mixed_sample, on (out_valid, out_stall).
// Write, length and trigger words are accepted while idle without a stall.
// A tick is accepted, then takes one scan step per voice, a drain step for
// the last sample store read, the gain multiply and the output register
// load, which waits until the register is free. The voice scan is bound by
// the single read port of the sample store. The result becomes valid in the
// same cycle as the next word can be accepted. The output register holds a
// finished word while the receiver stalls; a second tick may run meanwhile
// and then waits to load until it is taken. Reset stops all voices, clears
// positions and lengths, sets gain 0, the enable off and the voice count
// to 8. The sample store is not cleared. The user makes configuration writes
// (cfg_we, cfg_index, cfg_data) while idle; the block does not enforce it.
module polyphonic_sample_mixer_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          cmd,
  input  logic [psm_pkg::VIDX_W-1:0]          voice,
  input  logic [psm_pkg::ADDR_W-1:0]          word_addr,
  input  logic signed [psm_pkg::SAMPLE_W-1:0] word_data,
  input  logic [psm_pkg::LEN_W-1:0]           voice_length,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [psm_pkg::OUT_W-1:0]    mixed_sample,
  input  logic                                cfg_we,
  input  logic [psm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [psm_pkg::CFG_W-1:0]           cfg_data
);
  import psm_pkg::*;

  psm_cmd_t  ctrl_cmd;
  psm_stat_t dp_stat;

  // Sequencer.
  psm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (dp_stat),
    .cmd_o    (ctrl_cmd)
  );

  // Datapath.
  psm_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd_i        (ctrl_cmd),
    .stat         (dp_stat),
    .cmd          (cmd),
    .voice        (voice),
    .word_addr    (word_addr),
    .word_data    (word_data),
    .voice_length (voice_length),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .mixed_sample (mixed_sample)
  );

endmodule
